[sv/hsks_pkg.sv]
// ----------------------------------------------------------------------------
// hsks_pkg: shared types and constants for the heap sorted key store
// constants for capacity, operation and status codes, and the key type
// ----------------------------------------------------------------------------
package hsks_pkg;
    localparam int unsigned Capacity = 1024;
    localparam int unsigned AddrW    = (Capacity <= 2) ? 1 : $clog2(Capacity);
    localparam int unsigned CountW   = $clog2(Capacity + 1);
    localparam int unsigned PosW     = 10;
    localparam int unsigned KeyW     = 80;

    typedef logic [1:0] t_op;
    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_SORT   = 2'd1;
    localparam t_op OP_LOOKUP = 2'd2;
    localparam t_op OP_CLEAR  = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_PHASE = 2'd2;

    typedef logic [KeyW-1:0] t_key;

    typedef struct packed {
        t_op         operation;
        logic [15:0] key_high;
        logic [63:0] key_low;
    } t_req;

    typedef struct packed {
        t_status         status;
        logic            found;
        logic [PosW-1:0] position;
    } t_rsp;
endpackage

[sv/hsks_if.sv]
// ----------------------------------------------------------------------------
// hsks_req_if / hsks_rsp_if: valid/ready channels of the key store
// request channel carries the operation and key, response carries the result
// ----------------------------------------------------------------------------
interface hsks_req_if;
    import hsks_pkg::*;
    logic        valid;
    logic        ready;
    t_op         operation;
    logic [15:0] key_high;
    logic [63:0] key_low;
    modport source (output valid, operation, key_high, key_low, input ready);
    modport sink   (input valid, operation, key_high, key_low, output ready);
endinterface

interface hsks_rsp_if;
    import hsks_pkg::*;
    logic            valid;
    logic            ready;
    t_status         status;
    logic            found;
    logic [PosW-1:0] position;
    modport source (output valid, status, found, position, input ready);
    modport sink   (input valid, status, found, position, output ready);
endinterface

[sv/heap_sorted_key_store.sv]
// ----------------------------------------------------------------------------
// heap_sorted_key_store: 80-bit key store, max-heap insert, heapsort, search
// keys live in one synchronous ram with a registered read port:
// insert sifts up per level (read parent, compare, write), lookup probes by
// binary search (read, compare), sort swaps root and last (read, read, write)
// then sifts down per level (read left, read right, compare); input stalls meanwhile.
// clear and wrong-phase requests answer in the next cycle; one item at a time.
// synchronous active-low reset clears count, phase and control; ram is not
// cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
module heap_sorted_key_store (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsks_req_if.sink   i_req,
    hsks_rsp_if.source o_rsp
);
    import hsks_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_UP_RD  = 12'b000000000010,
        S_UP_CMP = 12'b000000000100,
        S_UP_WR  = 12'b000000001000,
        S_SW_RD  = 12'b000000010000,
        S_SW_RL  = 12'b000000100000,
        S_SW_WR  = 12'b000001000000,
        S_DN_RDL = 12'b000010000000,
        S_DN_RDR = 12'b000100000000,
        S_DN_CMP = 12'b001000000000,
        S_LK_RD  = 12'b010000000000,
        S_LK_CMP = 12'b100000000000
    } t_state;

    t_key mem [Capacity];
    logic             mem_we;
    logic [AddrW-1:0] mem_wa, mem_ra;
    t_key             mem_wd, r_rd;

    t_state            r_state, n_state;
    logic [CountW-1:0] r_count, n_count;
    logic              r_sorted, n_sorted;
    logic              r_ovalid, n_ovalid;
    t_rsp              r_rsp, n_rsp;
    t_key              r_key, n_key;     // key being moved / searched
    t_key              r_ka, n_ka;       // left child, or root during swap
    logic [CountW:0]   r_pos, n_pos;     // current index
    logic [CountW:0]   r_size, n_size;   // heap size during sort
    logic [CountW:0]   r_lo, n_lo, r_hi, n_hi;

    logic [CountW:0] left_idx, right_idx, mid;
    logic            use_right;
    t_key            big_key;
    logic [CountW:0] big_idx;
    assign left_idx  = {r_pos[CountW-1:0], 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign mid       = (r_lo + r_hi) >> 1;
    assign use_right = (right_idx < r_size) && (r_ka < r_rd);
    assign big_key   = use_right ? r_rd : r_ka;
    assign big_idx   = use_right ? right_idx : left_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    assign i_req.ready    = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.status   = r_rsp.status;
    assign o_rsp.found    = r_rsp.found;
    assign o_rsp.position = r_rsp.position;

    always_comb begin
        n_state = r_state; n_count = r_count; n_sorted = r_sorted;
        n_ovalid = r_ovalid; n_rsp = r_rsp; n_key = r_key; n_ka = r_ka;
        n_pos = r_pos; n_size = r_size; n_lo = r_lo; n_hi = r_hi;
        mem_we = 1'b0; mem_wa = r_pos[AddrW-1:0]; mem_wd = r_key;
        mem_ra = r_pos[AddrW-1:0];
        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_key = {i_req.key_high, i_req.key_low};
                    n_rsp = '{status: ST_OK, found: 1'b0, position: '0};
                    case (i_req.operation)
                        OP_INSERT: begin
                            if (r_sorted) begin
                                n_rsp.status = ST_PHASE; n_ovalid = 1'b1;
                            end else if (r_count >= CountW'(Capacity)) begin
                                n_rsp.status = ST_FULL; n_ovalid = 1'b1;
                            end else begin
                                n_pos = {1'b0, r_count};
                                n_count = r_count + 1'b1;
                                n_state = S_UP_RD;
                            end
                        end
                        OP_SORT: begin
                            if (r_sorted) begin
                                n_rsp.status = ST_PHASE; n_ovalid = 1'b1;
                            end else begin
                                n_sorted = 1'b1;
                                n_size = {1'b0, r_count};
                                if (r_count > CountW'(1)) begin
                                    n_state = S_SW_RD;
                                    n_pos = '0;
                                end else n_ovalid = 1'b1;
                            end
                        end
                        OP_LOOKUP: begin
                            if (!r_sorted) begin
                                n_rsp.status = ST_PHASE; n_ovalid = 1'b1;
                            end else if (r_count == '0) n_ovalid = 1'b1;
                            else begin
                                n_lo = '0;
                                n_hi = {1'b0, r_count} - 1'b1;
                                n_state = S_LK_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0; n_sorted = 1'b0; n_ovalid = 1'b1;
                        end
                        default: n_ovalid = 1'b1;
                    endcase
                end
            end
            // sift up: hole at r_pos holds r_key logically
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1; mem_wa = '0;
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end else begin
                    mem_ra = AddrW'((r_pos - 1'b1) >> 1);
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (r_rd >= r_key) begin
                    mem_we = 1'b1; n_ovalid = 1'b1; n_state = S_IDLE;
                end else begin
                    mem_we = 1'b1; mem_wd = r_rd;
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                n_pos = (r_pos - 1'b1) >> 1;
                n_state = S_UP_RD;
            end
            // swap root and last: root goes to r_ka, last becomes the hole key
            S_SW_RD: begin
                mem_ra = '0;
                n_state = S_SW_RL;
            end
            S_SW_RL: begin
                n_ka = r_rd;
                mem_ra = AddrW'(r_size - 1'b1);
                n_state = S_SW_WR;
            end
            S_SW_WR: begin
                mem_we = 1'b1; mem_wa = AddrW'(r_size - 1'b1);
                mem_wd = r_ka;
                n_key = r_rd;
                n_size = r_size - 1'b1;
                n_pos = '0;
                n_state = S_DN_RDL;
            end
            // sift down: hole at r_pos holds r_key logically
            S_DN_RDL: begin
                if (left_idx >= r_size) begin
                    mem_we = 1'b1;
                    if (r_size > (CountW + 1)'(1)) n_state = S_SW_RD;
                    else begin
                        n_ovalid = 1'b1; n_state = S_IDLE;
                    end
                end else begin
                    mem_ra = AddrW'(left_idx);
                    n_state = S_DN_RDR;
                end
            end
            S_DN_RDR: begin
                n_ka = r_rd;
                mem_ra = AddrW'(right_idx);
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (r_key >= big_key) begin
                    if (r_size > (CountW + 1)'(1)) n_state = S_SW_RD;
                    else begin
                        n_ovalid = 1'b1; n_state = S_IDLE;
                    end
                end else begin
                    mem_wd = big_key;
                    n_pos = big_idx;
                    n_state = S_DN_RDL;
                end
            end
            S_LK_RD: begin
                if (r_lo > r_hi || r_hi[CountW]) begin
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end else begin
                    mem_ra = AddrW'(mid);
                    n_pos = mid;
                    n_state = S_LK_CMP;
                end
            end
            S_LK_CMP: begin
                if (r_key == r_rd) begin
                    n_rsp.found = 1'b1;
                    n_rsp.position = PosW'(r_pos);
                    n_ovalid = 1'b1; n_state = S_IDLE;
                end else if (r_key < r_rd) begin
                    n_hi = r_pos - 1'b1;
                    n_state = S_LK_RD;
                end else begin
                    n_lo = r_pos + 1'b1;
                    n_state = S_LK_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_sorted <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count; r_sorted <= n_sorted; r_ovalid <= n_ovalid;
        end
        r_rsp <= n_rsp; r_key <= n_key; r_ka <= n_ka; r_size <= n_size;
        r_lo <= n_lo; r_hi <= n_hi; r_pos <= n_pos;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE));
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready);
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(Capacity));
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> o_rsp.valid);
endmodule

[tb/heap_sorted_key_store_test.sv]
// ----------------------------------------------------------------------------
// heap_sorted_key_store_test: self-checking bench for the heap sorted key store
// queue-fed driver with bursty valid, monitor with patterned ready stall,
// in-bench heap/sort/search predictor compared field by field per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module heap_sorted_key_store_test;
    import hsks_pkg::*;

    localparam int WatchLimit = 400000;

    logic i_clk;
    logic i_rst_n;

    hsks_req_if req_ch ();
    hsks_rsp_if rsp_ch ();

    heap_sorted_key_store DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // predictor state
    t_key        shadow_keys [Capacity];
    int unsigned shadow_count;
    bit          shadow_sorted;

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   n_errors;
    bit   stim_done;
    bit   drain_hold;

    function automatic void swap_keys(int unsigned a, int unsigned b);
        t_key t;
        t = shadow_keys[a];
        shadow_keys[a] = shadow_keys[b];
        shadow_keys[b] = t;
    endfunction

    function automatic void sift_down_heap(int unsigned heap_size);
        int unsigned p;
        int unsigned l;
        int unsigned big;
        p = 0;
        forever begin
            l = 2 * p + 1;
            if (l >= heap_size) break;
            big = l;
            if (l + 1 < heap_size && shadow_keys[l] < shadow_keys[l + 1]) big = l + 1;
            if (shadow_keys[p] >= shadow_keys[big]) break;
            swap_keys(p, big);
            p = big;
        end
    endfunction

    function automatic t_rsp apply_request(t_req r);
        t_rsp o;
        t_key k;
        int unsigned p;
        int lo;
        int hi;
        int mid;
        o = '0;
        k = {r.key_high, r.key_low};
        case (r.operation)
            OP_INSERT: begin
                if (shadow_sorted) o.status = ST_PHASE;
                else if (shadow_count >= Capacity) o.status = ST_FULL;
                else begin
                    p = shadow_count;
                    shadow_keys[p] = k;
                    while (p > 0 && shadow_keys[(p - 1) / 2] < shadow_keys[p]) begin
                        swap_keys((p - 1) / 2, p);
                        p = (p - 1) / 2;
                    end
                    shadow_count++;
                end
            end
            OP_SORT: begin
                if (shadow_sorted) o.status = ST_PHASE;
                else begin
                    for (int unsigned i = shadow_count; i > 1; i--) begin
                        swap_keys(0, i - 1);
                        sift_down_heap(i - 1);
                    end
                    shadow_sorted = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (!shadow_sorted) o.status = ST_PHASE;
                else begin
                    lo = 0;
                    hi = int'(shadow_count) - 1;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        if (k == shadow_keys[mid]) begin
                            o.found = 1'b1;
                            o.position = mid[PosW-1:0];
                            break;
                        end
                        if (k < shadow_keys[mid]) hi = mid - 1;
                        else lo = mid + 1;
                    end
                end
            end
            default: begin
                shadow_count = 0;
                shadow_sorted = 1'b0;
            end
        endcase
        return o;
    endfunction

    // stimulus construction; the key pool keeps duplicates and hits frequent
    t_key key_pool [$];

    function automatic t_key pick_key(bit from_pool);
        t_key k;
        if (from_pool && key_pool.size() > 0)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        case ($urandom_range(3))
            0: k = {16'(0), 64'($urandom_range(7))};
            1: k = {16'hffff, {$urandom, $urandom}};
            default: k = {16'($urandom), $urandom, $urandom};
        endcase
        if ($urandom_range(7) == 0) k = {16'($urandom_range(3)), 64'($urandom_range(3))};
        return k;
    endfunction

    task automatic push_req(t_op op, t_key k);
        t_req r;
        r.operation = op;
        r.key_high = k[79:64];
        r.key_low = k[63:0];
        pending_reqs.push_back(r);
        if (op == OP_INSERT) key_pool.push_back(k);
        if (op == OP_CLEAR) key_pool.delete();
    endtask

    task automatic build_set(int n_ins, int n_look);
        for (int i = 0; i < n_ins; i++) push_req(OP_INSERT, pick_key($urandom_range(3) == 0));
        push_req(OP_SORT, pick_key(0));
        for (int i = 0; i < n_look; i++) push_req(OP_LOOKUP, pick_key($urandom_range(2) != 0));
        if ($urandom_range(4) == 0) push_req(t_op'($urandom_range(3)), pick_key(0));
        push_req(OP_CLEAR, pick_key(0));
    endtask

    initial begin
        int total;
        n_errors = 0;
        stim_done = 1'b0;
        drain_hold = 1'b0;
        shadow_count = 0;
        shadow_sorted = 1'b0;
        i_rst_n = 1'b0;

        // directed: phase errors, empty store, extremes, duplicates
        push_req(OP_LOOKUP, '1);
        push_req(OP_SORT, '0);
        push_req(OP_LOOKUP, '0);
        push_req(OP_SORT, '0);
        push_req(OP_INSERT, '0);
        push_req(OP_CLEAR, '1);
        push_req(OP_INSERT, '1);
        push_req(OP_INSERT, '0);
        push_req(OP_INSERT, {16'h0000, 64'hffff_ffff_ffff_ffff});
        push_req(OP_INSERT, {16'h0001, 64'h0});
        push_req(OP_INSERT, '1);
        push_req(OP_INSERT, {16'h8000, 64'h8000_0000_0000_0000});
        push_req(OP_SORT, '0);
        push_req(OP_LOOKUP, '1);
        push_req(OP_LOOKUP, '0);
        push_req(OP_LOOKUP, {16'h0001, 64'h0});
        push_req(OP_LOOKUP, {16'h0000, 64'h1});
        push_req(OP_LOOKUP, {16'h8000, 64'h8000_0000_0000_0000});
        push_req(OP_CLEAR, '0);
        push_req(OP_INSERT, {16'h1234, 64'h5});
        push_req(OP_SORT, '0);
        push_req(OP_LOOKUP, {16'h1234, 64'h5});
        push_req(OP_CLEAR, '0);

        // one full store: fill to capacity, overflow, sort, search
        key_pool.delete();
        for (int i = 0; i < Capacity; i++) push_req(OP_INSERT, pick_key($urandom_range(7) == 0));
        push_req(OP_INSERT, '1);
        push_req(OP_INSERT, '0);
        push_req(OP_SORT, '0);
        for (int i = 0; i < 40; i++) push_req(OP_LOOKUP, pick_key($urandom_range(3) != 0));
        push_req(OP_CLEAR, '0);

        total = pending_reqs.size();
        while (pending_reqs.size() < total + 660) begin
            if ($urandom_range(9) == 0) push_req(t_op'($urandom_range(3)), pick_key(1));
            else build_set($urandom_range(24), $urandom_range(1, 12));
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: bursts and gaps; one mid-run pause until all results are back
    int  burst_left;
    int  gap_left;
    int  sent;
    bit  drained_once;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.operation <= OP_INSERT;
            req_ch.key_high <= '0;
            req_ch.key_low <= '0;
            burst_left <= 0;
            gap_left <= 0;
            sent <= 0;
            drained_once <= 1'b0;
        end else begin
            automatic bit busy = req_ch.valid && !req_ch.ready;
            automatic int s = sent;
            if (req_ch.valid && req_ch.ready) begin
                expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
                s = sent + 1;
                sent <= s;
            end
            if (!busy) begin
                if (s == 300 && !drained_once) begin
                    drain_hold = 1'b1;
                    if (expected_rsps.size() == 0) drained_once <= 1'b1;
                end else drain_hold = 1'b0;
                if (pending_reqs.size() == 0) begin
                    req_ch.valid <= 1'b0;
                    stim_done <= 1'b1;
                end else if (drain_hold) begin
                    req_ch.valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    req_ch.valid <= 1'b0;
                end else begin
                    req_ch.valid <= 1'b1;
                    req_ch.operation <= pending_reqs[0].operation;
                    req_ch.key_high <= pending_reqs[0].key_high;
                    req_ch.key_low <= pending_reqs[0].key_low;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(20);
                        gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
                    end
                end
            end
        end
    end

    // monitor: ready stall pattern alternates busy and free stretches
    int  stall_phase;
    bit  stall_mode;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_phase <= 0;
            stall_mode <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected beat: status %0d found %0d position %0d",
                           rsp_ch.status, rsp_ch.found, rsp_ch.position);
                    n_errors++;
                end else begin
                    automatic t_rsp e = expected_rsps.pop_front();
                    if (rsp_ch.status !== e.status) begin
                        $error("status: expected %0d actual %0d", e.status, rsp_ch.status);
                        n_errors++;
                    end
                    if (rsp_ch.found !== e.found) begin
                        $error("found: expected %0d actual %0d", e.found, rsp_ch.found);
                        n_errors++;
                    end
                    if (rsp_ch.position !== e.position) begin
                        $error("position: expected %0d actual %0d", e.position,
                               rsp_ch.position);
                        n_errors++;
                    end
                end
            end
            if (stall_phase == 0) begin
                stall_mode <= !stall_mode;
                stall_phase <= $urandom_range(1, 40);
            end else stall_phase <= stall_phase - 1;
            rsp_ch.ready <= stall_mode ? 1'b1 : (($urandom_range(3) != 0));
        end
    end

    // watchdog on cycles without any accepted beat; final check
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) idle_cycles <= 0;
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("heap_sorted_key_store verification failed");
            $finish;
        end
    end

    initial begin
        wait (stim_done === 1'b1);
        wait (expected_rsps.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && expected_rsps.size() == 0) begin
            $display("heap_sorted_key_store verification clean");
        end else begin
            $display("heap_sorted_key_store verification failed");
        end
        $finish;
    end
endmodule
